// ===== design/sled_pkg.sv =====
`default_nettype none

package sled_pkg;

    // Command codes of an input item.
    localparam logic [3:0] CMD_TICK     = 4'd0;
    localparam logic [3:0] CMD_VOLTAGE  = 4'd1;
    localparam logic [3:0] CMD_MOTION   = 4'd2;
    localparam logic [3:0] CMD_DOCKED   = 4'd3;
    localparam logic [3:0] CMD_HAZARD   = 4'd4;
    localparam logic [3:0] CMD_LINK     = 4'd5;
    localparam logic [3:0] CMD_OP_REQ   = 4'd6;
    localparam logic [3:0] CMD_OP_CLR   = 4'd7;
    localparam logic [3:0] CMD_SET_MODE = 4'd8;

    // Active event codes.
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_DOCKED   = 3'd1;
    localparam logic [2:0] EV_BATTERY  = 3'd2;
    localparam logic [2:0] EV_OPERATOR = 3'd3;
    localparam logic [2:0] EV_HAZARD   = 3'd4;
    localparam logic [2:0] EV_LINK     = 3'd5;

    // Operating modes.
    localparam logic [1:0] MODE_SAFE   = 2'd0;
    localparam logic [1:0] MODE_MANUAL = 2'd1;
    localparam logic [1:0] MODE_AUTO   = 2'd2;
    localparam logic [1:0] MODE_UNKN   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IDLE_THR  = 2'd0;
    localparam logic [1:0] CFG_DRIVE_THR = 2'd1;
    localparam logic [1:0] CFG_DEBOUNCE  = 2'd2;

    // Register reset values.
    localparam logic [15:0] IDLE_THR_RST  = 16'd23000;
    localparam logic [15:0] DRIVE_THR_RST = 16'd21000;
    localparam logic [6:0]  DEBOUNCE_RST  = 7'd40;

    // Frame timing.
    localparam logic [3:0] PHASE_LAST    = 4'd9;
    localparam logic [3:0] EVENT_PHASES  = 4'd3;

    typedef struct packed {
        logic [3:0]         command;
        logic [15:0]        voltage_mv;
        logic signed [15:0] forward_speed;
        logic signed [15:0] turn_rate;
        logic               flag_value;
        logic [1:0]         mode_code;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [2:0] active_event;
    } t_out_item;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    // Colour of an operating mode.
    function automatic t_rgb mode_colour(input logic [1:0] mode);
        t_rgb c;
        unique case (mode)
            MODE_SAFE:   c = '{r: 8'd0,   g: 8'd255, b: 8'd0};
            MODE_MANUAL: c = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
            MODE_AUTO:   c = '{r: 8'd255, g: 8'd192, b: 8'd0};
            default:     c = '{r: 8'd127, g: 8'd0,   b: 8'd127};
        endcase
        return c;
    endfunction

    // Colour of one frame phase for the given mode and event.
    function automatic t_rgb frame_colour(input logic [1:0] mode, input logic [2:0] ev,
                                          input logic [3:0] phase);
        t_rgb c;
        logic flash;
        c = mode_colour(mode);
        flash = (ev == EV_HAZARD) || (ev == EV_LINK);
        if (phase < EVENT_PHASES) begin
            unique case (ev)
                EV_DOCKED:   c = '{r: 8'd255, g: 8'd255, b: 8'd255};
                EV_BATTERY:  c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
                EV_OPERATOR: c = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
                EV_HAZARD:   c = '{r: 8'd255, g: 8'd0,   b: 8'd127};
                EV_LINK:     c = '{r: 8'd0,   g: 8'd255, b: 8'd192};
                default:     c = mode_colour(mode);
            endcase
        end else if (flash && (phase == 4'd3 || phase == 4'd4 || phase > 4'd6)) begin
            // Double flash: dark gaps around the second mode flash.
            c = '{r: 8'd0, g: 8'd0, b: 8'd0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/sled_item_if.sv =====
`default_nettype none

interface sled_item_if import sled_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/sled_result_if.sv =====
`default_nettype none

interface sled_result_if import sled_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/status_led_event_sequencer.sv =====
// Channel    Direction  Payload                                         Handshake
// i_item     in         command, voltage_mv, forward_speed, turn_rate,  valid/ready
//                       flag_value, mode_code
// o_result   out        red, green, blue, active_event                  valid/ready
// i_cfg_*    in         register index, 16-bit data                     write enable
//
// Takes one item per cycle unless a result stalls; a tick's frame is out next cycle.
// The single output register sets the rate: a new item is taken whenever that
// register is empty or being drained in the same cycle.
// Synchronous active-low reset clears all flags, the debounce count, the frame phase,
// the registers to their defaults and the output valid.
// A stalled result holds in the output register; input ready drops only then.
`default_nettype none

module status_led_event_sequencer import sled_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sled_item_if.sink        i_item,
    sled_result_if.source    o_result,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic [15:0] r_idle_thr;
    logic [15:0] r_drive_thr;
    logic [6:0]  r_debounce;

    logic [7:0]  r_count,     n_count;
    logic        r_batt_low,  n_batt_low;
    logic        r_driving,   n_driving;
    logic        r_docked,    n_docked;
    logic        r_hazard,    n_hazard;
    logic        r_link,      n_link;
    logic        r_operator,  n_operator;
    logic [1:0]  r_mode,      n_mode;
    logic [2:0]  r_event,     n_event;
    logic [3:0]  r_phase,     n_phase;

    logic        r_out_valid;
    t_out_item   r_out;

    logic        accept;
    logic        is_tick;
    logic        resolve;
    logic [15:0] thr;
    logic [7:0]  count_max;
    t_rgb        colour;
    t_in_item    item;

    // Accept while the output register is empty or being taken.
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign accept       = i_item.valid && i_item.ready;
    assign item         = i_item.data;
    assign is_tick      = accept && (item.command == CMD_TICK);

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_thr  <= IDLE_THR_RST;
            r_drive_thr <= DRIVE_THR_RST;
            r_debounce  <= DEBOUNCE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IDLE_THR:  r_idle_thr  <= i_cfg_data;
                CFG_DRIVE_THR: r_drive_thr <= i_cfg_data;
                CFG_DEBOUNCE:  r_debounce  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Next state of the flags and the debounce counter for one item.
    assign thr       = r_driving ? r_drive_thr : r_idle_thr;
    assign count_max = {r_debounce, 1'b0};

    always_comb begin
        n_count    = r_count;
        n_batt_low = r_batt_low;
        n_driving  = r_driving;
        n_docked   = r_docked;
        n_hazard   = r_hazard;
        n_link     = r_link;
        n_operator = r_operator;
        n_mode     = r_mode;
        resolve    = 1'b0;
        if (accept) begin
            unique case (item.command)
                CMD_VOLTAGE: begin
                    if (item.voltage_mv < thr && r_count < count_max) begin
                        n_count = r_count + 8'd1;
                    end else if (r_count != 8'd0) begin
                        n_count = r_count - 8'd1;
                    end
                    n_batt_low = n_count > {1'b0, r_debounce};
                    resolve    = 1'b1;
                end
                CMD_MOTION: begin
                    n_driving = (item.forward_speed > 16'sd0) || (item.turn_rate > 16'sd0);
                end
                CMD_DOCKED: begin
                    n_docked = item.flag_value;
                    resolve  = 1'b1;
                end
                CMD_HAZARD: begin
                    n_hazard = item.flag_value;
                    resolve  = 1'b1;
                end
                CMD_LINK: begin
                    n_link  = item.flag_value;
                    resolve = 1'b1;
                end
                CMD_OP_REQ: begin
                    n_operator = 1'b1;
                    resolve    = 1'b1;
                end
                CMD_OP_CLR: begin
                    n_operator = 1'b0;
                    resolve    = 1'b1;
                end
                CMD_SET_MODE: begin
                    n_mode = item.mode_code;
                end
                default: ;
            endcase
        end
    end

    // Fixed-priority event resolution, done only by the voltage, docked, hazard, link and operator commands.
    always_comb begin
        n_event = r_event;
        if (resolve) begin
            priority if (n_hazard)   n_event = EV_HAZARD;
            else if (n_link)         n_event = EV_LINK;
            else if (n_batt_low)     n_event = EV_BATTERY;
            else if (n_docked)       n_event = EV_DOCKED;
            else if (n_operator)     n_event = EV_OPERATOR;
            else                     n_event = EV_NONE;
        end
    end

    // Frame phase advances on every tick and wraps after the tenth phase.
    always_comb begin
        n_phase = r_phase;
        if (is_tick) begin
            n_phase = (r_phase == PHASE_LAST) ? 4'd0 : r_phase + 4'd1;
        end
    end

    assign colour = frame_colour(r_mode, r_event, r_phase);

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_batt_low <= 1'b0;
            r_driving  <= 1'b0;
            r_docked   <= 1'b0;
            r_hazard   <= 1'b0;
            r_link     <= 1'b0;
            r_operator <= 1'b0;
            r_mode     <= MODE_SAFE;
            r_event    <= EV_NONE;
            r_phase    <= '0;
        end else begin
            r_count    <= n_count;
            r_batt_low <= n_batt_low;
            r_driving  <= n_driving;
            r_docked   <= n_docked;
            r_hazard   <= n_hazard;
            r_link     <= n_link;
            r_operator <= n_operator;
            r_mode     <= n_mode;
            r_event    <= n_event;
            r_phase    <= n_phase;
        end
    end

    // Output register: loaded by a tick, cleared when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (is_tick) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_tick) begin
            r_out.red          <= colour.r;
            r_out.green        <= colour.g;
            r_out.blue         <= colour.b;
            r_out.active_event <= r_event;
        end
    end

endmodule

`default_nettype wire

// ===== design/sled_checker.sv =====
`default_nettype none

module sled_checker import sled_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      i_in_ready,
    input wire t_in_item  i_in_data,
    input wire logic      i_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item i_out_data
);

    // A stalled result keeps its value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    // Input is never held off while the output side can take a result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled without output backpressure");

    // A new result follows only an accepted tick.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_data.command == CMD_TICK))
        else $error("result without a tick");

    // The reported event is always a defined code.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.active_event <= EV_LINK)
        else $error("undefined event code");

    // No result is pending right after reset.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind status_led_event_sequencer sled_checker u_sled_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_data   (i_item.data),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.data)
);

`default_nettype wire

// ===== verif/status_led_event_sequencer_tb.sv =====
`default_nettype none

module status_led_event_sequencer_tb;
    import sled_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_MAX    = 20;

    // Commands past the last defined one; the block must ignore them.
    localparam logic [3:0] CMD_UNUSED_FIRST = 4'd9;
    localparam logic [3:0] CMD_UNUSED_LAST  = 4'd15;
    // Register index with no register behind it.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // Frame colours as {red, green, blue}.
    localparam logic [23:0] RGB_GREEN  = 24'h00FF00;
    localparam logic [23:0] RGB_BLUE   = 24'h0000FF;
    localparam logic [23:0] RGB_AMBER  = 24'hFFC000;
    localparam logic [23:0] RGB_PURPLE = 24'h7F007F;
    localparam logic [23:0] RGB_WHITE  = 24'hFFFFFF;
    localparam logic [23:0] RGB_RED    = 24'hFF0000;
    localparam logic [23:0] RGB_PINK   = 24'hFF007F;
    localparam logic [23:0] RGB_TEAL   = 24'h00FFC0;
    localparam logic [23:0] RGB_BLACK  = 24'h000000;

    // Phases that go dark during a hazard or link-lost double flash.
    localparam logic [9:0] DARK_PHASES = 10'b11_1001_1000;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item frame;
    } t_plan_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [15:0] i_cfg_data;

    sled_item_if   item_bus();
    sled_result_if res_bus();

    status_led_event_sequencer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_bus),
        .o_result    (res_bus),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow of the LED controller state, updated on every accepted item.
    logic [15:0] idle_thr     = IDLE_THR_RST;
    logic [15:0] drive_thr    = DRIVE_THR_RST;
    logic [6:0]  debounce_lim = DEBOUNCE_RST;
    logic [7:0]  low_count    = '0;
    bit          batt_low     = 1'b0;
    bit          moving       = 1'b0;
    bit          docked       = 1'b0;
    bit          hazard       = 1'b0;
    bit          link_lost    = 1'b0;
    bit          op_wait      = 1'b0;
    logic [1:0]  led_mode     = MODE_SAFE;
    logic [2:0]  active_ev    = EV_NONE;
    logic [3:0]  frame_phase  = '0;

    t_out_item pending_frames[$];
    t_plan_row directed_plan[$];

    // Sideband that travels with the item on the bus: a hand-typed frame, if any.
    bit        row_typed;
    t_out_item row_frame;

    int  cycle_count    = 0;
    int  items_sent     = 0;
    int  frames_seen    = 0;
    int  mismatch_count = 0;
    int  event_frames[8];
    bit  send_steady    = 1'b0;
    bit  take_steady    = 1'b0;

    // Fixed priority among the status flags.
    function automatic logic [2:0] rank_event();
        if (hazard) return EV_HAZARD;
        if (link_lost) return EV_LINK;
        if (batt_low) return EV_BATTERY;
        if (docked) return EV_DOCKED;
        if (op_wait) return EV_OPERATOR;
        return EV_NONE;
    endfunction

    // Colour of the current frame phase.
    function automatic t_out_item paint_frame();
        logic [23:0] rgb;
        case (led_mode)
            MODE_SAFE:   rgb = RGB_GREEN;
            MODE_MANUAL: rgb = RGB_BLUE;
            MODE_AUTO:   rgb = RGB_AMBER;
            default:     rgb = RGB_PURPLE;
        endcase
        if (frame_phase < EVENT_PHASES) begin
            case (active_ev)
                EV_DOCKED:   rgb = RGB_WHITE;
                EV_BATTERY:  rgb = RGB_RED;
                EV_OPERATOR: rgb = RGB_BLUE;
                EV_HAZARD:   rgb = RGB_PINK;
                EV_LINK:     rgb = RGB_TEAL;
                default:     ;
            endcase
        end else if ((active_ev == EV_HAZARD || active_ev == EV_LINK) &&
                     DARK_PHASES[frame_phase]) begin
            rgb = RGB_BLACK;
        end
        return {rgb, active_ev};
    endfunction

    // Applies one item to the shadow state; a tick also yields its frame.
    task automatic take_led_item(input t_in_item it, output bit gives_frame,
                                 output t_out_item frame);
        logic [15:0] thr;
        gives_frame = 1'b0;
        frame = '0;
        case (it.command)
            CMD_VOLTAGE: begin
                thr = moving ? drive_thr : idle_thr;
                if (it.voltage_mv < thr && low_count < {debounce_lim, 1'b0})
                    low_count = low_count + 8'd1;
                else if (low_count != 8'd0)
                    low_count = low_count - 8'd1;
                batt_low = low_count > {1'b0, debounce_lim};
                active_ev = rank_event();
            end
            CMD_MOTION: begin
                moving = ($signed(it.forward_speed) > 0) || ($signed(it.turn_rate) > 0);
            end
            CMD_DOCKED: begin
                docked = it.flag_value;
                active_ev = rank_event();
            end
            CMD_HAZARD: begin
                hazard = it.flag_value;
                active_ev = rank_event();
            end
            CMD_LINK: begin
                link_lost = it.flag_value;
                active_ev = rank_event();
            end
            CMD_OP_REQ: begin
                op_wait = 1'b1;
                active_ev = rank_event();
            end
            CMD_OP_CLR: begin
                op_wait = 1'b0;
                active_ev = rank_event();
            end
            CMD_SET_MODE: begin
                led_mode = it.mode_code;
            end
            CMD_TICK: begin
                gives_frame = 1'b1;
                frame = paint_frame();
                frame_phase = (frame_phase == PHASE_LAST) ? 4'd0 : frame_phase + 4'd1;
            end
            default: ;
        endcase
    endtask

    task automatic apply_register(input logic [1:0] index, input logic [15:0] word);
        case (index)
            CFG_IDLE_THR:  idle_thr = word;
            CFG_DRIVE_THR: drive_thr = word;
            CFG_DEBOUNCE:  debounce_lim = word[6:0];
            default:       ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("[%0t] frame %0d: %s got %0d expected %0d",
                     $realtime, frames_seen, what, got, want);
    endtask

    task automatic check_frame(input t_out_item got);
        t_out_item want;
        frames_seen++;
        event_frames[got.active_event]++;
        if (pending_frames.size() == 0) begin
            report_mismatch("frame with nothing pending", got, 0);
        end else begin
            want = pending_frames.pop_front();
            if (got.red !== want.red) report_mismatch("red", got.red, want.red);
            if (got.green !== want.green) report_mismatch("green", got.green, want.green);
            if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
            if (got.active_event !== want.active_event)
                report_mismatch("active_event", got.active_event, want.active_event);
        end
    endtask

    // Watch both channels and the register port; frames are checked before new
    // items are applied so the order inside a clock edge never matters.
    always @(posedge i_clk) begin
        bit        gives;
        t_out_item frame;
        if (i_rst_n) begin
            if (res_bus.valid && res_bus.ready) check_frame(res_bus.data);
            if (i_cfg_we) apply_register(i_cfg_index, i_cfg_data);
            if (item_bus.valid && item_bus.ready) begin
                take_led_item(item_bus.data, gives, frame);
                if (gives) pending_frames.push_back(row_typed ? row_frame : frame);
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Run limit reached with %0d frames still pending.", pending_frames.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: a random stall before each frame, with stall-free stretches.
    initial begin
        int stall;
        res_bus.ready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 59) == 0) take_steady = !take_steady;
            stall = take_steady ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_bus.valid && res_bus.ready));
        end
    end

    // Offer one item after a random gap and hold it until it is taken.
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item typed_frame);
        int gap;
        if ($urandom_range(0, 59) == 0) send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_bus.valid <= 1'b1;
        item_bus.data  <= it;
        row_typed      <= typed;
        row_frame      <= typed_frame;
        do @(posedge i_clk); while (!(item_bus.valid && item_bus.ready));
        items_sent++;
    endtask

    // Stop sending and wait until every pending frame has come out.
    task automatic settle();
        item_bus.valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] index, input logic [15:0] word);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= word;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_plan_row plan_row(input logic [3:0] cmd, input logic [15:0] volt,
                                           input logic [15:0] fwd, input logic [15:0] turn,
                                           input logic flag, input logic [1:0] mode,
                                           input bit typed, input t_out_item frame);
        t_plan_row row;
        row.item.command       = cmd;
        row.item.voltage_mv    = volt;
        row.item.forward_speed = fwd;
        row.item.turn_rate     = turn;
        row.item.flag_value    = flag;
        row.item.mode_code     = mode;
        row.typed              = typed;
        row.frame              = frame;
        return row;
    endfunction

    // Speeds lean on zero and the sign boundaries.
    function automatic logic [15:0] pick_speed();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'h8000;
            2:       return 16'h7FFF;
            3:       return 16'h0001;
            4:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random item; voltage samples stay mostly on one side of the thresholds so
    // the debounce counter climbs into low battery and back down again.
    function automatic t_in_item random_item(input logic [15:0] thr_a, input logic [15:0] thr_b,
                                             input bit low_side);
        t_in_item    it;
        int          pick;
        int          sel;
        logic [15:0] lo_thr;
        logic [15:0] hi_thr;
        logic [15:0] limit_mv;
        lo_thr = (thr_a < thr_b) ? thr_a : thr_b;
        hi_thr = (thr_a < thr_b) ? thr_b : thr_a;
        it.voltage_mv    = 16'($urandom);
        it.forward_speed = pick_speed();
        it.turn_rate     = pick_speed();
        it.flag_value    = 1'($urandom);
        it.mode_code     = 2'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            it.command = CMD_TICK;
        end else if (pick < 70) begin
            it.command = CMD_VOLTAGE;
            sel = $urandom_range(0, 19);
            if (sel == 0) begin
                it.voltage_mv = 16'($urandom);
            end else if (sel == 1) begin
                it.voltage_mv = low_side ? lo_thr : hi_thr;
            end else if (low_side) begin
                limit_mv = (sel < 11) ? hi_thr : lo_thr;
                it.voltage_mv = (limit_mv == 16'd0) ? 16'd0
                                                    : 16'($urandom_range(0, limit_mv - 1));
            end else begin
                it.voltage_mv = 16'($urandom_range(hi_thr, 16'hFFFF));
            end
        end else if (pick < 76) begin
            it.command = CMD_MOTION;
        end else if (pick < 80) begin
            it.command = CMD_DOCKED;
        end else if (pick < 84) begin
            it.command    = CMD_HAZARD;
            it.flag_value = ($urandom_range(0, 9) < 3);
        end else if (pick < 88) begin
            it.command    = CMD_LINK;
            it.flag_value = ($urandom_range(0, 9) < 3);
        end else if (pick < 91) begin
            it.command = CMD_OP_REQ;
        end else if (pick < 94) begin
            it.command = CMD_OP_CLR;
        end else if (pick < 97) begin
            it.command = CMD_SET_MODE;
        end else begin
            it.command = 4'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
        end
        return it;
    endfunction

    // One register setting followed by a stretch of random items.
    task automatic run_setting(input logic [15:0] idle_word, input logic [15:0] drive_word,
                               input logic [15:0] debounce_word, input int n_items,
                               input int flip_odds);
        bit low_side;
        settle();
        cfg_write(CFG_IDLE_THR, idle_word);
        cfg_write(CFG_DRIVE_THR, drive_word);
        cfg_write(CFG_DEBOUNCE, debounce_word);
        low_side = 1'b1;
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(0, flip_odds - 1) == 0) low_side = !low_side;
            send_item(random_item(idle_word, drive_word, low_side), 1'b0, '0);
        end
    endtask

    initial begin
        logic [15:0] thr_a;
        logic [15:0] thr_b;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_IDLE_THR;
        i_cfg_data     = '0;
        item_bus.valid = 1'b0;
        item_bus.data  = '0;
        row_typed      = 1'b0;
        row_frame      = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk under reset register values: every command, an ignored
        // code, speed sign boundaries, event priority and the double flash.
        directed_plan.push_back(plan_row(CMD_TICK, 16'hFFFF, 16'h7FFF, 16'h7FFF, 1'b1,
                                         MODE_UNKN, 1'b1, {RGB_GREEN, EV_NONE}));
        directed_plan.push_back(plan_row(CMD_UNUSED_LAST, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
                                         MODE_UNKN, 1'b0, '0));
        directed_plan.push_back(plan_row(CMD_SET_MODE, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                                         MODE_UNKN, 1'b0, '0));
        directed_plan.push_back(plan_row(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                                         MODE_SAFE, 1'b1, {RGB_PURPLE, EV_NONE}));
        directed_plan.push_back(plan_row(CMD_MOTION, 16'h0000, 16'h7FFF, 16'h8000, 1'b0,
                                         MODE_SAFE, 1'b0, '0));
        directed_plan.push_back(plan_row(CMD_MOTION, 16'h0000, 16'h8000, 16'h0000, 1'b0,
                                         MODE_SAFE, 1'b0, '0));
        directed_plan.push_back(plan_row(CMD_MOTION, 16'h0000, 16'h0000, 16'h0001, 1'b0,
                                         MODE_SAFE, 1'b0, '0));
        directed_plan.push_back(plan_row(CMD_DOCKED, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                                         MODE_SAFE, 1'b0, '0));
        directed_plan.push_back(plan_row(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                                         MODE_SAFE, 1'b1, {RGB_WHITE, EV_DOCKED}));
        // Operator commands ignore the flag bit.
        directed_plan.push_back(plan_row(CMD_OP_REQ, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                                         MODE_SAFE, 1'b0, '0));
        directed_plan.push_back(plan_row(CMD_DOCKED, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                                         MODE_SAFE, 1'b0, '0));
        directed_plan.push_back(plan_row(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                                         MODE_SAFE, 1'b1, {RGB_PURPLE, EV_OPERATOR}));
        directed_plan.push_back(plan_row(CMD_OP_CLR, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                                         MODE_SAFE, 1'b0, '0));
        directed_plan.push_back(plan_row(CMD_HAZARD, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                                         MODE_SAFE, 1'b0, '0));
        directed_plan.push_back(plan_row(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                                         MODE_SAFE, 1'b1, {RGB_BLACK, EV_HAZARD}));
        directed_plan.push_back(plan_row(CMD_LINK, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                                         MODE_SAFE, 1'b0, '0));
        directed_plan.push_back(plan_row(CMD_HAZARD, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                                         MODE_SAFE, 1'b0, '0));
        directed_plan.push_back(plan_row(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                                         MODE_SAFE, 1'b1, {RGB_PURPLE, EV_LINK}));
        directed_plan.push_back(plan_row(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                                         MODE_SAFE, 1'b0, '0));
        directed_plan.push_back(plan_row(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                                         MODE_SAFE, 1'b0, '0));
        directed_plan.push_back(plan_row(CMD_LINK, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                                         MODE_SAFE, 1'b0, '0));
        directed_plan.push_back(plan_row(CMD_VOLTAGE, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                                         MODE_SAFE, 1'b0, '0));
        directed_plan.push_back(plan_row(CMD_VOLTAGE, 16'hFFFF, 16'h0000, 16'h0000, 1'b0,
                                         MODE_SAFE, 1'b0, '0));
        directed_plan.push_back(plan_row(CMD_SET_MODE, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                                         MODE_AUTO, 1'b0, '0));
        directed_plan.push_back(plan_row(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                                         MODE_SAFE, 1'b0, '0));
        foreach (directed_plan[i])
            send_item(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].frame);

        // Threshold extremes with the smallest limits; upper data bits of the
        // debounce write must be dropped.
        run_setting(16'hFFFF, 16'h0000, 16'h0001, 300, 60);
        run_setting(16'h0000, 16'hFFFF, 16'hFF83, 300, 60);
        // Full debounce limit needs long runs on one side to saturate.
        thr_a = 16'($urandom_range(18000, 26000));
        thr_b = 16'($urandom_range(18000, 26000));
        run_setting(thr_a, thr_b, 16'hFFFF, 500, 500);
        // Zero limit: the counter can never rise. The unused index must be ignored.
        settle();
        cfg_write(CFG_UNUSED, 16'($urandom));
        run_setting(16'hFFFF, 16'hFFFF, 16'h0000, 250, 80);
        thr_a = 16'($urandom);
        thr_b = 16'($urandom);
        run_setting(thr_a, thr_b, 16'($urandom_range(1, 20)), 500, 150);
        settle();

        $display("Sent %0d items over the reset values and five register settings, with zero,",
                 items_sent);
        $display("small and full debounce limits; %0d frames checked, per event %0d/%0d/%0d/%0d/%0d/%0d.",
                 frames_seen, event_frames[EV_NONE], event_frames[EV_DOCKED],
                 event_frames[EV_BATTERY], event_frames[EV_OPERATOR],
                 event_frames[EV_HAZARD], event_frames[EV_LINK]);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches.", mismatch_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
